// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the servo pulse sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge while out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain condition checked on every rising clock edge while out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- rtl/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Constants and helpers for the servo pulse sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned Channels = 8;
  localparam int unsigned ChanW = 3;
  localparam int unsigned PosW = 12;
  localparam int unsigned WidthW = 8;
  localparam int unsigned CntW = 9;
  localparam int unsigned FrameW = 16;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PosW-1:0] CenterPosition = 12'd1500;
  localparam logic [FrameW-1:0] FrameTicksReset = 16'd2500;
  localparam logic [CntW-1:0] LeadGapReset = 9'd21;

  localparam logic CfgFrameTicks = 1'b0;
  localparam logic CfgLeadGap = 1'b1;

  localparam logic ModeTick = 1'b0;
  localparam logic ModeWrite = 1'b1;

  // Microseconds to 8 us ticks, truncated, saturated at the width maximum.
  function automatic logic [WidthW-1:0] pos_to_width(input logic [PosW-1:0] pos);
    logic [PosW-4:0] w;
    w = pos[PosW-1:3];
    if (w[PosW-4:WidthW] != '0) begin
      return '1;
    end
    return w[WidthW-1:0];
  endfunction

endpackage

// ----- rtl/servo_pulse_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// servo_pulse_sequencer_core
// Eight-channel sequential servo pulse generator driven by 8 us tick items.
// ----------------------------------------------------------------------------
// Each input transfer is either one time-base tick or a channel position
// write (microseconds). Every frame the widths are latched as position/8,
// saturated at 255; after the lead gap each channel is high for width+1
// ticks in turn. One item is accepted per clock; its result appears in the
// output register on the next cycle. The only limit on throughput is that
// single output register: input stalls only while a held result is itself
// stalled. Configuration writes are always ready.
`include "assert_macros.svh"

module servo_pulse_sequencer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [sps_pkg::ChanW-1:0]         channel_i,
  input  logic [sps_pkg::PosW-1:0]          position_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sps_pkg::Channels-1:0]      pulse_lines_o,
  output logic                              frame_start_o,
  output logic                              busy_res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [sps_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhLead  = 2'd1;
  localparam logic [1:0] PhPulse = 2'd2;

  logic [sps_pkg::FrameW-1:0] frame_ticks_q;
  logic [sps_pkg::CntW-1:0]   lead_gap_q;

  logic [sps_pkg::PosW-1:0]   pos_q   [sps_pkg::Channels];
  logic [sps_pkg::WidthW-1:0] width_q [sps_pkg::Channels];
  logic [sps_pkg::WidthW-1:0] width_d [sps_pkg::Channels];

  logic [sps_pkg::FrameW-1:0] frame_cnt_q, frame_cnt_d;
  logic [sps_pkg::CntW-1:0]   pulse_cnt_q, pulse_cnt_d;
  logic [sps_pkg::ChanW-1:0]  chan_q, chan_d;
  logic [1:0]                 phase_q, phase_d;

  logic                       out_valid_q;
  logic [sps_pkg::Channels-1:0] lines_q, lines_d;
  logic                       start_q, start_d;
  logic                       busy_q, busy_d;

  logic accept;
  logic start;
  logic [1:0] phase_mid;
  logic [sps_pkg::CntW-1:0] cnt_mid;
  logic [sps_pkg::CntW-1:0] cnt_dec;
  logic [sps_pkg::ChanW-1:0] chan_inc;
  logic [sps_pkg::FrameW:0] frame_inc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ticks_q <= sps_pkg::FrameTicksReset;
      lead_gap_q    <= sps_pkg::LeadGapReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == sps_pkg::CfgFrameTicks) begin
        frame_ticks_q <= cfg_data_i;
      end else begin
        lead_gap_q <= cfg_data_i[sps_pkg::CntW-1:0];
      end
    end
  end

  assign start     = (mode_i == sps_pkg::ModeTick) && (frame_cnt_q == '0);
  assign frame_inc = {1'b0, frame_cnt_q} + {{sps_pkg::FrameW{1'b0}}, 1'b1};
  assign chan_inc  = chan_q + 1'b1;

  always_comb begin
    for (int k = 0; k < sps_pkg::Channels; k++) begin
      width_d[k] = start ? sps_pkg::pos_to_width(pos_q[k]) : width_q[k];
    end

    phase_mid = phase_q;
    cnt_mid   = pulse_cnt_q;
    if (start && phase_q == PhIdle) begin
      phase_mid = PhLead;
      cnt_mid   = (lead_gap_q == '0) ? {{(sps_pkg::CntW-1){1'b0}}, 1'b1} : lead_gap_q;
    end
    cnt_dec = cnt_mid - 1'b1;

    frame_cnt_d = frame_cnt_q;
    if (mode_i == sps_pkg::ModeTick) begin
      if (frame_inc >= {1'b0, frame_ticks_q}) begin
        frame_cnt_d = '0;
      end else begin
        frame_cnt_d = frame_inc[sps_pkg::FrameW-1:0];
      end
    end

    lines_d = '0;
    if (phase_mid == PhPulse) begin
      lines_d[chan_q] = 1'b1;
    end
    start_d = start;
    busy_d  = (phase_mid != PhIdle);

    phase_d     = phase_mid;
    pulse_cnt_d = cnt_mid;
    chan_d      = chan_q;
    if (mode_i == sps_pkg::ModeTick) begin
      case (phase_mid)
        PhLead: begin
          pulse_cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d     = PhPulse;
            chan_d      = '0;
            pulse_cnt_d = {1'b0, width_d[0]} + 1'b1;
          end
        end
        PhPulse: begin
          pulse_cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            if (chan_q == sps_pkg::ChanW'(sps_pkg::Channels - 1)) begin
              phase_d = PhIdle;
              chan_d  = '0;
            end else begin
              chan_d      = chan_inc;
              pulse_cnt_d = {1'b0, width_d[chan_inc]} + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sps_pkg::Channels; k++) begin
        pos_q[k]   <= sps_pkg::CenterPosition;
        width_q[k] <= '0;
      end
      frame_cnt_q <= '0;
      pulse_cnt_q <= '0;
      chan_q      <= '0;
      phase_q     <= PhIdle;
    end else if (accept) begin
      if (mode_i == sps_pkg::ModeWrite) begin
        pos_q[channel_i] <= position_i;
      end else begin
        for (int k = 0; k < sps_pkg::Channels; k++) begin
          width_q[k] <= width_d[k];
        end
        frame_cnt_q <= frame_cnt_d;
        pulse_cnt_q <= pulse_cnt_d;
        chan_q      <= chan_d;
        phase_q     <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lines_q <= lines_d;
      start_q <= start_d;
      busy_q  <= busy_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_lines_o = lines_q;
  assign frame_start_o = start_q;
  assign busy_res_o    = busy_q;

  `ASSERT_ALWAYS(a_lines_onehot0, clk_i, rst_ni, !out_valid_q || $onehot0(lines_q), "pulse lines not one-hot")
  `ASSERT_IMP(a_lines_busy, clk_i, rst_ni, out_valid_q && (lines_q != '0), busy_q, "line high while not busy")
  `ASSERT_IMP(a_idle_chan, clk_i, rst_ni, phase_q == PhIdle, chan_q == '0, "channel nonzero while idle")
  `ASSERT_IMP(a_run_cnt, clk_i, rst_ni, phase_q != PhIdle, pulse_cnt_q != '0, "zero count while running")

endmodule
